// ----- rtl/ntsq_pkg.sv -----
// shared types, constants and sine table builder for the note sequencer tone generator
`default_nettype none

package ntsq_pkg;

   typedef logic [1:0] opcode_type;

   localparam opcode_type OP_TICK  = 2'd0;
   localparam opcode_type OP_WRITE = 2'd1;
   localparam opcode_type OP_STOP  = 2'd2;
   localparam opcode_type OP_PAUSE = 2'd3;

   localparam int INDEX_BITS    = 8;
   localparam int DURATION_BITS = 24;
   localparam int STEP_BITS     = 32;
   localparam int LENGTH_BITS   = 9;
   localparam int SAMPLE_BITS   = 16;
   localparam int REQ_DATA_BITS = 72;
   localparam int RSP_DATA_BITS = 32;

   localparam int RSP_FIFO_DEPTH = 4;

   localparam int SINE_ROM_DEPTH = 1024;
   localparam int SINE_ADDR_BITS = 10;

   localparam logic [SAMPLE_BITS-1:0] SQUARE_HIGH = 16'h7fff;
   localparam logic [SAMPLE_BITS-1:0] SQUARE_LOW  = 16'h8000;

   localparam logic [63:0] HALF_PI_Q30 = 64'd1686629713;
   localparam logic [63:0] TAYLOR_DIV [7] = '{64'd6, 64'd20, 64'd42, 64'd72, 64'd110,
                                              64'd156, 64'd210};

   typedef logic [SAMPLE_BITS-1:0] sine_rom_type [SINE_ROM_DEPTH];

   // quarter-wave table, odd taylor terms through x^15 in q30
   function automatic sine_rom_type build_sine_rom();
      sine_rom_type rom;
      logic [63:0]  x;
      logic [63:0]  term;
      logic [63:0]  sum;
      logic [63:0]  val;
      for (int k = 0; k < SINE_ROM_DEPTH; k++) begin
         x    = (HALF_PI_Q30 * (64'(2 * k) + 64'd1)) / 64'(2 * SINE_ROM_DEPTH);
         term = x;
         sum  = x;
         for (int n = 1; n <= 7; n++) begin
            term = (term * x) >> 30;
            term = (term * x) >> 30;
            term = term / TAYLOR_DIV[n - 1];
            if (n[0]) begin
               sum = (sum >= term) ? sum - term : 64'd0;
            end else begin
               sum = sum + term;
            end
         end
         val = (sum * 64'd32767 + 64'd536870912) >> 30;
         if (val > 64'd32767) begin
            val = 64'd32767;
         end
         rom[k] = val[SAMPLE_BITS-1:0];
      end
      return rom;
   endfunction

endpackage

`default_nettype wire

// ----- rtl/ntsq_wrap_div.sv -----
// bit-serial remainder unit for the wrap position after a length change
`default_nettype none

module ntsq_wrap_div #(
   parameter int NUM_W = 9,
   parameter int DEN_W = 9
) (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             start,
   input  wire logic [NUM_W-1:0] num,
   input  wire logic [DEN_W-1:0] den,
   output logic                  busy,
   output logic                  done,
   output logic      [DEN_W-1:0] rem
);

   localparam int CNT_W = $clog2(NUM_W + 1);

   logic [NUM_W-1:0] num_ff, num_in;
   logic [DEN_W-1:0] den_ff, den_in;
   logic [DEN_W-1:0] rem_ff, rem_in;
   logic [CNT_W-1:0] cnt_ff, cnt_in;
   logic             busy_ff, busy_in;
   logic             done_ff, done_in;
   logic [DEN_W:0]   trial;

   always_comb begin
      trial   = {rem_ff, num_ff[NUM_W-1]};
      num_in  = num_ff;
      den_in  = den_ff;
      rem_in  = rem_ff;
      cnt_in  = cnt_ff;
      busy_in = busy_ff;
      done_in = 1'b0;
      if (start) begin
         num_in  = num;
         den_in  = den;
         rem_in  = '0;
         cnt_in  = CNT_W'(NUM_W);
         busy_in = 1'b1;
      end else if (busy_ff) begin
         num_in = {num_ff[NUM_W-2:0], 1'b0};
         if (trial >= {1'b0, den_ff}) begin
            rem_in = DEN_W'(trial - {1'b0, den_ff});
         end else begin
            rem_in = trial[DEN_W-1:0];
         end
         cnt_in = cnt_ff - CNT_W'(1);
         if (cnt_ff == CNT_W'(1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff  <= '0;
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         cnt_ff  <= cnt_in;
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
   end

   always_ff @(posedge clock) begin
      num_ff <= num_in;
      den_ff <= den_in;
      rem_ff <= rem_in;
   end

   assign busy = busy_ff;
   assign done = done_ff;
   assign rem  = rem_ff;

endmodule

`default_nettype wire

// ----- rtl/ntsq_sine_rom.sv -----
// quarter-wave sine rom with registered read
`default_nettype none

module ntsq_sine_rom import ntsq_pkg::*; (
   input  wire logic                      clock,
   input  wire logic [SINE_ADDR_BITS-1:0] addr,
   output logic      [SAMPLE_BITS-1:0]    data_ff
);

   localparam sine_rom_type SINE_TABLE = build_sine_rom();

   always_ff @(posedge clock) begin
      data_ff <= SINE_TABLE[addr];
   end

endmodule

`default_nettype wire

// ----- rtl/ntsq_out_fifo.sv -----
// small result fifo between the sample pipeline and the result channel
`default_nettype none

module ntsq_out_fifo import ntsq_pkg::*; (
   input  wire logic                   clock,
   input  wire logic                   reset,
   input  wire logic                   push,
   input  wire logic [SAMPLE_BITS-1:0] push_data,
   input  wire logic                   pop,
   output logic                        valid,
   output logic      [SAMPLE_BITS-1:0] data
);

   localparam int PTR_W = $clog2(RSP_FIFO_DEPTH);

   logic [SAMPLE_BITS-1:0] slot_ff [RSP_FIFO_DEPTH];
   logic [PTR_W-1:0]       wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0]       rd_ptr_ff, rd_ptr_in;
   logic [PTR_W:0]         fill_ff, fill_in;
   logic                   pop_ok;

   assign valid  = (fill_ff != '0);
   assign data   = slot_ff[rd_ptr_ff];
   assign pop_ok = pop && valid;

   always_comb begin
      wr_ptr_in = push ? wr_ptr_ff + PTR_W'(1) : wr_ptr_ff;
      rd_ptr_in = pop_ok ? rd_ptr_ff + PTR_W'(1) : rd_ptr_ff;
      fill_in   = fill_ff + (PTR_W + 1)'(push) - (PTR_W + 1)'(pop_ok);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         fill_ff   <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         fill_ff   <= fill_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         slot_ff[wr_ptr_ff] <= push_data;
      end
   end

endmodule

`default_nettype wire

// ----- rtl/note_sequencer_tone_generator_top.sv -----
// Looping note sequencer driving a phase-accumulator tone generator. Every request
// (tick, pattern write, stop, pause) can be followed by a new one in the next cycle
// while req_tready is high; it drops while all result credits are in use or while the
// remainder unit is busy. A tick's sample passes the s1 and s2 stage registers and a
// four-entry result fifo, which keeps requests flowing while a sample waits. The note
// store is a synchronous single-write, single-read memory read at the play position,
// which the sequencer stage forwards straight into the read address so consecutive
// ticks never wait. A write of pattern_length holds req_tready low while a bit-serial
// remainder unit recomputes the wrap position. Reading a pattern entry that was never
// written gives an undefined sample.
`default_nettype none

module note_sequencer_tone_generator_top import ntsq_pkg::*; #(
   parameter int MAX_NOTES  = 256,
   parameter int PHASE_BITS = 32
) (
   input  wire logic                     clock,
   input  wire logic                     reset,
   input  wire logic                     req_tvalid,
   output logic                          req_tready,
   // opcode, entry_index, note_duration, phase_step, wave_kind, zero pad
   input  wire logic [REQ_DATA_BITS-1:0] req_tdata,
   output logic                          rsp_tvalid,
   input  wire logic                     rsp_tready,
   // left_sample, right_sample
   output logic      [RSP_DATA_BITS-1:0] rsp_tdata,
   input  wire logic                     csr_psel,
   input  wire logic                     csr_penable,
   input  wire logic                     csr_pwrite,
   input  wire logic [2:0]               csr_paddr,
   input  wire logic [31:0]              csr_pwdata,
   output logic      [31:0]              csr_prdata,
   output logic                          csr_pready
);

   localparam int ADDR_W   = $clog2(MAX_NOTES);
   localparam int LEN_W    = $clog2(MAX_NOTES + 1);
   localparam int CMP_W    = LEN_W + ADDR_W;
   localparam int IDX_W    = ADDR_W + INDEX_BITS;
   localparam int CREDIT_W = $clog2(RSP_FIFO_DEPTH + 1);

   localparam logic CSR_SEL_LENGTH = 1'b0;

   typedef struct packed {
      logic [DURATION_BITS-1:0] duration;
      logic [STEP_BITS-1:0]     step;
      logic                     kind;
   } note_type;

   // request fields
   opcode_type               req_opcode;
   logic [INDEX_BITS-1:0]    req_entry_index;
   logic [DURATION_BITS-1:0] req_note_duration;
   logic [STEP_BITS-1:0]     req_phase_step;
   logic                     req_wave_kind;
   logic                     req_xfer;
   logic                     rsp_xfer;

   assign req_opcode        = req_tdata[1:0];
   assign req_entry_index   = req_tdata[9:2];
   assign req_note_duration = req_tdata[33:10];
   assign req_phase_step    = req_tdata[65:34];
   assign req_wave_kind     = req_tdata[66];

   // note store
   note_type          note_mem [MAX_NOTES];
   note_type          rd_note_ff;
   logic [IDX_W-1:0]  idx_ext;
   logic              mem_we;

   // sequencer state
   logic [ADDR_W-1:0]        pos_ff, pos_in;
   logic [ADDR_W-1:0]        next_pos_ff, next_pos_in;
   logic [ADDR_W-1:0]        next_wrap;
   logic [DURATION_BITS-1:0] count_ff, count_in;
   logic [PHASE_BITS-1:0]    phase_ff, phase_in;
   logic [PHASE_BITS+STEP_BITS-1:0] step_wide;
   logic                     advance;

   // pipeline
   logic       s1_valid_ff;
   opcode_type s1_op_ff;
   logic       s2_tick_ff;
   logic       s2_square_ff;
   logic       s2_neg_ff;

   // sample path
   logic [1:0]                quad;
   logic [SINE_ADDR_BITS-1:0] rom_addr;
   logic [SAMPLE_BITS-1:0]    rom_data;
   logic [SAMPLE_BITS-1:0]    sample;
   logic [SAMPLE_BITS-1:0]    fifo_data;

   // credits and configuration
   logic [CREDIT_W-1:0]    credit_ff, credit_in;
   logic [LENGTH_BITS-1:0] len_ff;
   logic [LEN_W-1:0]       eff_len_ff;
   logic [LEN_W-1:0]       eff_wr;
   logic [LENGTH_BITS-1:0] len_wr;
   logic                   csr_write;
   logic                   len_write;
   logic                   div_busy;
   logic                   div_done;
   logic [LEN_W-1:0]       div_rem;

   assign req_xfer = req_tvalid && req_tready;
   assign rsp_xfer = rsp_tvalid && rsp_tready;

   assign idx_ext = IDX_W'(req_entry_index);
   assign mem_we  = req_xfer && (req_opcode == OP_WRITE) && (idx_ext < IDX_W'(MAX_NOTES));

   always_ff @(posedge clock) begin
      if (mem_we) begin
         note_mem[idx_ext[ADDR_W-1:0]] <= '{duration: req_note_duration,
                                            step:     req_phase_step,
                                            kind:     req_wave_kind};
      end
      rd_note_ff <= note_mem[pos_in];
   end

   // sequencer stage
   assign advance   = (count_ff >= rd_note_ff.duration);
   assign step_wide = (PHASE_BITS + STEP_BITS)'(rd_note_ff.step);
   assign next_wrap = (CMP_W'(next_pos_ff) + CMP_W'(1) == CMP_W'(eff_len_ff)) ?
                      '0 : next_pos_ff + ADDR_W'(1);

   always_comb begin
      pos_in      = pos_ff;
      next_pos_in = next_pos_ff;
      count_in    = count_ff;
      phase_in    = phase_ff;
      if (s1_valid_ff) begin
         case (s1_op_ff)
            OP_TICK: begin
               phase_in = phase_ff + step_wide[PHASE_BITS-1:0];
               if (advance) begin
                  pos_in      = next_pos_ff;
                  next_pos_in = next_wrap;
                  count_in    = DURATION_BITS'(1);
               end else begin
                  count_in = count_ff + DURATION_BITS'(1);
               end
            end
            OP_STOP: begin
               pos_in      = '0;
               next_pos_in = (eff_len_ff == LEN_W'(1)) ? '0 : ADDR_W'(1);
               count_in    = '0;
            end
            OP_PAUSE: begin
               count_in = '0;
            end
            default: begin
            end
         endcase
      end
      if (div_done) begin
         next_pos_in = div_rem[ADDR_W-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pos_ff      <= '0;
         next_pos_ff <= '0;
         count_ff    <= '0;
         phase_ff    <= '0;
         s1_valid_ff <= 1'b0;
         s2_tick_ff  <= 1'b0;
      end else begin
         pos_ff      <= pos_in;
         next_pos_ff <= next_pos_in;
         count_ff    <= count_in;
         phase_ff    <= phase_in;
         s1_valid_ff <= req_xfer;
         s2_tick_ff  <= s1_valid_ff && (s1_op_ff == OP_TICK);
      end
   end

   // quadrant fold of the new phase into the rom address
   assign quad     = phase_in[PHASE_BITS-1 -: 2];
   assign rom_addr = quad[0] ? ~phase_in[PHASE_BITS-3 -: SINE_ADDR_BITS] :
                                phase_in[PHASE_BITS-3 -: SINE_ADDR_BITS];

   always_ff @(posedge clock) begin
      s1_op_ff     <= req_opcode;
      s2_square_ff <= rd_note_ff.kind;
      s2_neg_ff    <= quad[1];
   end

   ntsq_sine_rom u_sine_rom (
      .clock   (clock),
      .addr    (rom_addr),
      .data_ff (rom_data)
   );

   always_comb begin
      if (s2_square_ff) begin
         sample = s2_neg_ff ? SQUARE_LOW : SQUARE_HIGH;
      end else begin
         sample = s2_neg_ff ? SAMPLE_BITS'(0) - rom_data : rom_data;
      end
   end

   ntsq_out_fifo u_out_fifo (
      .clock     (clock),
      .reset     (reset),
      .push      (s2_tick_ff),
      .push_data (sample),
      .pop       (rsp_tready),
      .valid     (rsp_tvalid),
      .data      (fifo_data)
   );

   assign rsp_tdata = {fifo_data, fifo_data};

   // one credit per tick in flight or waiting in the fifo
   always_comb begin
      credit_in = credit_ff
                + CREDIT_W'(req_xfer && (req_opcode == OP_TICK))
                - CREDIT_W'(rsp_xfer);
   end

   assign req_tready = !div_busy && (credit_ff < CREDIT_W'(RSP_FIFO_DEPTH));

   // register port
   assign csr_pready = 1'b1;
   assign csr_write  = csr_psel && csr_penable && csr_pwrite && csr_pready;
   assign len_write  = csr_write && (csr_paddr[2] == CSR_SEL_LENGTH);
   assign len_wr     = csr_pwdata[LENGTH_BITS-1:0];
   assign csr_prdata = (csr_paddr[2] == CSR_SEL_LENGTH) ? 32'(len_ff) : '0;

   always_comb begin
      if (len_wr == '0) begin
         eff_wr = LEN_W'(1);
      end else if (32'(len_wr) > 32'(MAX_NOTES)) begin
         eff_wr = LEN_W'(MAX_NOTES);
      end else begin
         eff_wr = LEN_W'(len_wr);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         credit_ff  <= '0;
         len_ff     <= LENGTH_BITS'(1);
         eff_len_ff <= LEN_W'(1);
      end else begin
         credit_ff <= credit_in;
         if (len_write) begin
            len_ff     <= len_wr;
            eff_len_ff <= eff_wr;
         end
      end
   end

   ntsq_wrap_div #(
      .NUM_W (ADDR_W + 1),
      .DEN_W (LEN_W)
   ) u_wrap_div (
      .clock (clock),
      .reset (reset),
      .start (len_write),
      .num   ((ADDR_W + 1)'(pos_ff) + (ADDR_W + 1)'(1)),
      .den   (eff_wr),
      .busy  (div_busy),
      .done  (div_done),
      .rem   (div_rem)
   );

   a_credit_bound : assert property (@(posedge clock) disable iff (reset)
      credit_ff <= CREDIT_W'(RSP_FIFO_DEPTH))
      else $error("more ticks outstanding than result slots");

   a_wrap_in_range : assert property (@(posedge clock) disable iff (reset)
      (!div_busy && !div_done) |-> (CMP_W'(next_pos_ff) < CMP_W'(eff_len_ff)))
      else $error("wrap position outside pattern length");

   a_stop_rewinds : assert property (@(posedge clock) disable iff (reset)
      (s1_valid_ff && (s1_op_ff == OP_STOP)) |=> ((pos_ff == '0) && (count_ff == '0)))
      else $error("stop did not rewind position and count");

endmodule

`default_nettype wire

// ----- test/tb.sv -----
// self-checking testbench for the note sequencer tone generator top level
`timescale 1ns / 1ps

module tb;
   import ntsq_pkg::*;

   localparam logic [2:0] REG_PATTERN_LENGTH = 3'd0;
   localparam int NOTE_SLOTS = 256;

   typedef struct packed {
      opcode_type  opcode;
      logic [7:0]  index;
      logic [23:0] duration;
      logic [31:0] step;
      logic        kind;
      logic        produces;
      logic [15:0] sample;
   } tone_item;

   logic                     clock = 1'b0;
   logic                     reset = 1'b1;
   logic                     req_tvalid = 1'b0;
   logic                     req_tready;
   logic [REQ_DATA_BITS-1:0] req_tdata = '0;
   logic                     rsp_tvalid;
   logic                     rsp_tready = 1'b0;
   logic [RSP_DATA_BITS-1:0] rsp_tdata;
   logic                     csr_psel = 1'b0;
   logic                     csr_penable = 1'b0;
   logic                     csr_pwrite = 1'b0;
   logic [2:0]               csr_paddr = '0;
   logic [31:0]              csr_pwdata = '0;
   logic [31:0]              csr_prdata;
   logic                     csr_pready;

   // predicted sequencer state
   logic [15:0] quarter_sine [1024];
   logic [23:0] note_length_tab [NOTE_SLOTS];
   logic [31:0] note_step_tab [NOTE_SLOTS];
   logic        note_square_tab [NOTE_SLOTS];
   bit          note_loaded [NOTE_SLOTS];
   int unsigned play_slot = 0;
   logic [23:0] note_age = '0;
   logic [31:0] phase_acc = '0;
   logic [8:0]  loop_length = 9'd1;

   tone_item    pending [$];
   logic [15:0] expected_samples [$];
   tone_item    on_wire;
   logic        req_taken = 1'b0;
   int          send_gap = 0;
   int          stall_left = 0;
   int          idle_pct = 20;
   int          issued = 0;
   int          accepted = 0;
   int          mismatches = 0;

   note_sequencer_tone_generator_top dut (
      .clock       (clock),
      .reset       (reset),
      .req_tvalid  (req_tvalid),
      .req_tready  (req_tready),
      .req_tdata   (req_tdata),
      .rsp_tvalid  (rsp_tvalid),
      .rsp_tready  (rsp_tready),
      .rsp_tdata   (rsp_tdata),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready)
   );

   always #5 clock = ~clock;

   function automatic int unsigned loop_span();
      if (loop_length == 9'd0) return 1;
      if (loop_length > NOTE_SLOTS) return NOTE_SLOTS;
      return loop_length;
   endfunction

   function automatic logic [15:0] sine_of(logic [31:0] ph);
      logic [9:0]  addr;
      logic [15:0] mag;
      addr = ph[29:20];
      if (ph[30]) addr = 10'd1023 - addr;
      mag = quarter_sine[addr];
      return ph[31] ? 16'd0 - mag : mag;
   endfunction

   function automatic tone_item predict_sample(tone_item it);
      int unsigned slot;
      it.produces = 1'b0;
      it.sample = '0;
      case (it.opcode)
         OP_WRITE: begin
            note_length_tab[it.index] = it.duration;
            note_step_tab[it.index] = it.step;
            note_square_tab[it.index] = it.kind;
            note_loaded[it.index] = 1'b1;
         end
         OP_STOP: begin
            play_slot = 0;
            note_age = '0;
         end
         OP_PAUSE: begin
            note_age = '0;
         end
         OP_TICK: begin
            slot = play_slot;
            if (note_age >= note_length_tab[slot]) begin
               note_age = '0;
               play_slot = (play_slot + 1) % loop_span();
            end
            phase_acc = phase_acc + note_step_tab[slot];
            it.produces = 1'b1;
            if (note_square_tab[slot]) begin
               it.sample = phase_acc[31] ? SQUARE_LOW : SQUARE_HIGH;
            end else begin
               it.sample = sine_of(phase_acc);
            end
            note_age = note_age + 24'd1;
         end
      endcase
      return it;
   endfunction

   function automatic tone_item directed(opcode_type op, logic [7:0] index,
                                         logic [23:0] duration, logic [31:0] step,
                                         logic kind);
      tone_item it;
      it = '0;
      it.opcode = op;
      it.index = index;
      it.duration = duration;
      it.step = step;
      it.kind = kind;
      return it;
   endfunction

   function automatic tone_item junk_item(opcode_type op);
      return directed(op, 8'($urandom()), 24'($urandom()), $urandom(), 1'($urandom()));
   endfunction

   function automatic tone_item note_write(logic [7:0] slot);
      tone_item it;
      int       pick;
      it = junk_item(OP_WRITE);
      it.index = slot;
      pick = $urandom_range(0, 99);
      if (pick < 60) begin
         it.duration = 24'($urandom_range(0, 4));
      end else if (pick < 85) begin
         it.duration = 24'($urandom_range(5, 40));
      end
      return it;
   endfunction

   task automatic queue_item(tone_item it);
      pending.push_back(predict_sample(it));
      issued++;
   endtask

   // never let a tick land on a slot that has not been loaded
   task automatic queue_tick(tone_item it);
      if (!note_loaded[play_slot]) queue_item(note_write(8'(play_slot)));
      it.opcode = OP_TICK;
      queue_item(it);
   endtask

   task automatic drain_and_settle();
      while (accepted != issued || expected_samples.size() != 0) @(negedge clock);
      repeat (8) @(negedge clock);
   endtask

   task automatic set_pattern_length(logic [31:0] value);
      @(negedge clock);
      csr_psel <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite <= 1'b1;
      csr_paddr <= REG_PATTERN_LENGTH;
      csr_pwdata <= value;
      @(negedge clock);
      csr_penable <= 1'b1;
      @(posedge clock);
      while (!csr_pready) @(posedge clock);
      @(negedge clock);
      csr_psel <= 1'b0;
      csr_penable <= 1'b0;
      csr_pwrite <= 1'b0;
      loop_length = value[8:0];
   endtask

   task automatic random_phase(int count);
      int roll;
      for (int n = 0; n < count; n++) begin
         roll = $urandom_range(0, 99);
         if (roll < 68) begin
            queue_tick(junk_item(OP_TICK));
         end else if (roll < 86) begin
            if ($urandom_range(0, 9) < 7) begin
               queue_item(note_write(8'($urandom_range(0, loop_span() - 1))));
            end else begin
               queue_item(note_write(8'($urandom())));
            end
         end else if (roll < 93) begin
            queue_item(junk_item(OP_STOP));
         end else begin
            queue_item(junk_item(OP_PAUSE));
         end
      end
   endtask

   task automatic report_mismatch(string what, logic [15:0] got, logic [15:0] want);
      $display("%0t: %s got %h, expected %h", $time, what, got, want);
      mismatches++;
   endtask

   always @(negedge clock) begin : request_driver
      if (!reset && (!req_tvalid || req_taken)) begin
         if (send_gap != 0) begin
            send_gap--;
            req_tvalid <= 1'b0;
         end else if (pending.size() == 0) begin
            req_tvalid <= 1'b0;
         end else if ($urandom_range(0, 99) < idle_pct) begin
            send_gap = $urandom_range(0, 5);
            req_tvalid <= 1'b0;
         end else begin
            on_wire = pending.pop_front();
            req_tdata <= {5'd0, on_wire.kind, on_wire.step, on_wire.duration,
                          on_wire.index, on_wire.opcode};
            req_tvalid <= 1'b1;
         end
      end
   end

   always @(negedge clock) begin : result_receiver
      if (stall_left != 0) begin
         stall_left--;
         rsp_tready <= 1'b0;
      end else if ($urandom_range(0, 99) < idle_pct) begin
         stall_left = $urandom_range(0, 5);
         rsp_tready <= 1'b0;
      end else begin
         rsp_tready <= 1'b1;
      end
   end

   always @(posedge clock) begin : transfer_monitor
      logic [15:0] want;
      if (reset) begin
         req_taken <= 1'b0;
      end else begin
         req_taken <= req_tvalid && req_tready;
         if (req_tvalid && req_tready) begin
            accepted++;
            if (on_wire.produces) expected_samples.push_back(on_wire.sample);
         end
         if (rsp_tvalid && rsp_tready) begin
            if (expected_samples.size() == 0) begin
               report_mismatch("unexpected sample transfer", rsp_tdata[15:0], 16'd0);
            end else begin
               want = expected_samples.pop_front();
               if (rsp_tdata[15:0] !== want) begin
                  report_mismatch("left_sample", rsp_tdata[15:0], want);
               end
               if (rsp_tdata[31:16] !== want) begin
                  report_mismatch("right_sample", rsp_tdata[31:16], want);
               end
            end
         end
      end
   end

   initial begin : stimulus
      logic [63:0] x;
      logic [63:0] term;
      logic [63:0] sum;
      logic [63:0] val;
      logic [31:0] setting;
      // quarter-wave table, taylor series in q30
      for (int k = 0; k < 1024; k++) begin
         x = (64'd1686629713 * (64'(2 * k) + 64'd1)) / 64'd2048;
         term = x;
         sum = x;
         for (int n = 1; n <= 7; n++) begin
            term = (term * x) >> 30;
            term = (term * x) >> 30;
            term = term / 64'((2 * n) * (2 * n + 1));
            if (n % 2 == 1) begin
               sum = (sum >= term) ? sum - term : 64'd0;
            end else begin
               sum = sum + term;
            end
         end
         val = (sum * 64'd32767 + 64'd536870912) >> 30;
         if (val > 64'd32767) val = 64'd32767;
         quarter_sine[k] = val[15:0];
      end

      repeat (10) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // one turn in quarter steps walks every quadrant; then square notes, pause and stop
      queue_item(directed(OP_WRITE, 8'd0, 24'd2, 32'h4000_0000, 1'b0));
      repeat (4) queue_tick('0);
      queue_item(directed(OP_WRITE, 8'd255, 24'hff_ffff, 32'hffff_ffff, 1'b1));
      queue_item(directed(OP_WRITE, 8'd0, 24'd0, 32'hffff_ffff, 1'b1));
      repeat (2) queue_tick('0);
      queue_item(directed(OP_PAUSE, 8'd0, 24'd0, 32'd0, 1'b0));
      queue_tick('0);
      queue_item(directed(OP_STOP, 8'd0, 24'd0, 32'd0, 1'b0));
      queue_tick('0);
      queue_item(directed(OP_WRITE, 8'd0, 24'd1, 32'd0, 1'b0));
      repeat (2) queue_tick('0);
      queue_item(directed(OP_WRITE, 8'd0, 24'hff_ffff, 32'h8000_0000, 1'b1));
      repeat (2) queue_tick('0);
      drain_and_settle();

      // zero length behaves as one
      set_pattern_length(32'd0);
      repeat (2) queue_tick('0);
      drain_and_settle();

      // walk forward, then shrink the loop below the play position
      set_pattern_length(32'd256);
      queue_item(directed(OP_WRITE, 8'd0, 24'd0, 32'h0000_1000, 1'b0));
      queue_item(directed(OP_WRITE, 8'd1, 24'd0, 32'h0123_4567, 1'b0));
      queue_item(directed(OP_WRITE, 8'd2, 24'd0, 32'h89ab_cdef, 1'b1));
      queue_item(directed(OP_WRITE, 8'd3, 24'd0, 32'h7fff_ffff, 1'b0));
      repeat (4) queue_tick('0);
      drain_and_settle();
      set_pattern_length(32'd2);
      repeat (3) queue_tick('0);
      drain_and_settle();
      set_pattern_length(32'd511);
      repeat (2) queue_tick('0);

      for (int p = 0; p < 10; p++) begin
         drain_and_settle();
         case (p)
            0: setting = 32'd256;
            1: setting = 32'd1;
            2: setting = 32'd2;
            3: setting = 32'd511;
            4: setting = 32'd0;
            9: setting = 32'd256;
            default: setting = 32'($urandom_range(0, 511));
         endcase
         if ($urandom_range(0, 1) == 1) setting = setting | ($urandom() & 32'hffff_fe00);
         set_pattern_length(setting);
         case ($urandom_range(0, 3))
            0: idle_pct = 0;
            1: idle_pct = 10;
            2: idle_pct = 25;
            default: idle_pct = 40;
         endcase
         if (p == 9) idle_pct = 0;
         if ($urandom_range(0, 1) == 1) begin
            for (int s = 0; s < 8 && s < loop_span(); s++) queue_item(note_write(8'(s)));
         end
         random_phase(100);
      end
      drain_and_settle();

      if (mismatches == 0) begin
         $display("note_sequencer_tone_generator_top verification clean");
      end else begin
         $display("note_sequencer_tone_generator_top verification failed");
      end
      $finish;
   end

   initial begin : watchdog
      #5_000_000;
      $display("note_sequencer_tone_generator_top verification failed");
      $finish;
   end

endmodule
